// File: hw/rtl/pulse_beat_rate_detector_defines.svh
// Assertion macros used by the detector checker.
`ifndef PULSE_BEAT_RATE_DETECTOR_DEFINES_SVH
`define PULSE_BEAT_RATE_DETECTOR_DEFINES_SVH

// Check a property outside reset.
`define PBRD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define PBRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/pbrd_pkg.sv
// Shared types, constants and register codes of the pulse beat rate detector.
`timescale 1ns / 1ps
package pbrd_pkg;

   localparam int SAMPLE_BITS       = 10;
   localparam int HISTORY_DEPTH_DEF = 10;
   localparam int MAX_RECORDS_DEF   = 20;
   localparam int INTERVAL_BITS     = 12;
   localparam int INTERVAL_MAX      = 4095;
   localparam int RATE_NUMERATOR    = 60000;
   localparam int RATE_BITS         = 16;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 12;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_PERIOD  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INIT_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INIT_LEVEL     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TROUGH_HOLD    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REFRACTORY     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT        = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECORD_LOW     = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECORD_HIGH    = 3'd7;

   typedef struct packed {
      logic [7:0]               sample_period_ms;
      logic [SAMPLE_BITS-1:0]   initial_threshold;
      logic [SAMPLE_BITS-1:0]   initial_level;
      logic [INTERVAL_BITS-1:0] trough_hold_ms;
      logic [INTERVAL_BITS-1:0] refractory_ms;
      logic [INTERVAL_BITS-1:0] timeout_ms;
      logic [7:0]               record_low_bpm;
      logic [7:0]               record_high_bpm;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      sample_period_ms:  8'd2,
      initial_threshold: 10'd530,
      initial_level:     10'd512,
      trough_hold_ms:    12'd150,
      refractory_ms:     12'd250,
      timeout_ms:        12'd2500,
      record_low_bpm:    8'd60,
      record_high_bpm:   8'd100
   };

   // What the front end hands to the rate engine for one item.
   typedef struct packed {
      logic                     compute;
      logic                     seed;
      logic                     pulse;
      logic [SAMPLE_BITS-1:0]   threshold;
      logic [INTERVAL_BITS-1:0] interval;
   } job_type;

endpackage

// File: hw/rtl/pbrd_divider.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pbrd_divider #(
   parameter int W = 17
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W + 1);

   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic [W+1:0]  diff;
   logic          ge;

   always_comb begin
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      diff    = {1'b0, shifted} - {2'b00, div_ff};
      ge      = !diff[W+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[W:0] : shifted;
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/pbrd_queue.sv
// Two-entry job queue between the front end and the rate engine.
`timescale 1ns / 1ps
module pbrd_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pbrd_pkg::job_type push_data,
   input  logic             pop,
   output pbrd_pkg::job_type pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pbrd_pkg::job_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/pbrd_front.sv
// Front end: millisecond clock, peak and trough tracking, beat and timeout detection.
`timescale 1ns / 1ps
module pbrd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  pbrd_pkg::cfg_type                  cfg,
   input  logic                               accept,
   input  logic [pbrd_pkg::SAMPLE_BITS-1:0]   sample,
   output pbrd_pkg::job_type                  job
);

   localparam int SB = pbrd_pkg::SAMPLE_BITS;
   localparam int IB = pbrd_pkg::INTERVAL_BITS;

   logic [31:0]   time_ff, time_in, last_ff, last_in;
   logic [SB-1:0] peak_ff, peak_in, trough_ff, trough_in, thr_ff, thr_in;
   logic          pulse_ff, pulse_in, first_ff, first_in, second_ff, second_in;

   always_comb begin
      logic [31:0]   time_sum;
      logic [31:0]   n;
      logic [IB-1:0] interval;
      logic          beat;
      logic          armed_only;
      logic signed [SB:0] amp;
      logic signed [SB:0] half;
      logic signed [SB:0] level;

      time_sum   = time_ff + {24'b0, cfg.sample_period_ms};
      n          = time_sum - last_ff;
      interval   = (n > 32'(pbrd_pkg::INTERVAL_MAX)) ? IB'(pbrd_pkg::INTERVAL_MAX) : n[IB-1:0];
      beat       = 1'b0;
      armed_only = 1'b0;
      amp        = '0;
      half       = '0;
      level      = '0;

      time_in   = time_ff;
      last_in   = last_ff;
      peak_in   = peak_ff;
      trough_in = trough_ff;
      thr_in    = thr_ff;
      pulse_in  = pulse_ff;
      first_in  = first_ff;
      second_in = second_ff;

      job.compute   = 1'b0;
      job.seed      = 1'b0;

      if (accept) begin
         time_in = time_sum;
         if (sample < thr_ff && n > {20'b0, cfg.trough_hold_ms} && sample < trough_ff) begin
            trough_in = sample;
         end
         if (sample > thr_ff && sample > peak_ff) begin
            peak_in = sample;
         end
         beat = (n > {20'b0, cfg.refractory_ms}) && (n > {20'b0, cfg.trough_hold_ms})
                && (sample > thr_ff) && !pulse_ff;
         if (beat) begin
            pulse_in = 1'b1;
            last_in  = time_sum;
            if (second_ff) begin
               second_in = 1'b0;
               job.seed  = 1'b1;
            end
            if (first_ff) begin
               // first beat only arms; skip the rest of the step
               first_in   = 1'b0;
               second_in  = 1'b1;
               armed_only = 1'b1;
            end else begin
               job.compute = 1'b1;
            end
         end
         if (!armed_only) begin
            if (sample < thr_ff && pulse_in) begin
               amp   = $signed({1'b0, peak_in}) - $signed({1'b0, trough_in});
               half  = (amp >= 0) ? (amp >>> 1) : -((-amp) >>> 1);
               level = $signed({1'b0, trough_in}) + half;
               pulse_in  = 1'b0;
               thr_in    = level[SB-1:0];
               peak_in   = level[SB-1:0];
               trough_in = level[SB-1:0];
            end
            if (n > {20'b0, cfg.timeout_ms}) begin
               thr_in    = cfg.initial_threshold;
               peak_in   = cfg.initial_level;
               trough_in = cfg.initial_level;
               last_in   = time_sum;
               first_in  = 1'b1;
               second_in = 1'b0;
            end
         end
      end

      job.pulse     = pulse_in;
      job.threshold = thr_in;
      job.interval  = interval;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff   <= '0;
         last_ff   <= '0;
         peak_ff   <= pbrd_pkg::CFG_RESET.initial_level;
         trough_ff <= pbrd_pkg::CFG_RESET.initial_level;
         thr_ff    <= pbrd_pkg::CFG_RESET.initial_threshold;
         pulse_ff  <= 1'b0;
         first_ff  <= 1'b1;
         second_ff <= 1'b0;
      end else begin
         time_ff   <= time_in;
         last_ff   <= last_in;
         peak_ff   <= peak_in;
         trough_ff <= trough_in;
         thr_ff    <= thr_in;
         pulse_ff  <= pulse_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

// File: hw/rtl/pbrd_back.sv
// Rate engine: interval history, rate and record average through a shared divider.
`timescale 1ns / 1ps
module pbrd_back #(
   parameter int HISTORY_DEPTH = pbrd_pkg::HISTORY_DEPTH_DEF,
   parameter int MAX_RECORDS   = pbrd_pkg::MAX_RECORDS_DEF,
   parameter int CNT_W         = $clog2(MAX_RECORDS + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [7:0]                           record_low_bpm,
   input  logic [7:0]                           record_high_bpm,
   input  logic                                 job_ready,
   input  pbrd_pkg::job_type                    job,
   output logic                                 job_pop,
   input  logic                                 rsp_pop,
   output logic                                 rsp_empty,
   output logic [7:0]                           rsp_beats_per_minute,
   output logic                                 rsp_new_rate,
   output logic                                 rsp_in_pulse,
   output logic [pbrd_pkg::SAMPLE_BITS-1:0]     rsp_current_threshold,
   output logic [pbrd_pkg::INTERVAL_BITS-1:0]   rsp_beat_interval,
   output logic [CNT_W-1:0]                     rsp_recorded_count,
   output logic [7:0]                           rsp_recorded_average,
   output logic                                 rsp_average_in_band
);

   localparam int IB    = pbrd_pkg::INTERVAL_BITS;
   localparam int RB    = pbrd_pkg::RATE_BITS;
   localparam int SUM_W = $clog2(HISTORY_DEPTH * pbrd_pkg::INTERVAL_MAX + 1);
   localparam int REC_W = $clog2(MAX_RECORDS * 255 + 1);
   localparam int DIV_A = (SUM_W > REC_W) ? SUM_W : REC_W;
   localparam int DIV_W = (DIV_A > RB) ? DIV_A : RB;
   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   // mean = sum / HISTORY_DEPTH as a multiply by a rounded-up reciprocal
   localparam int MEAN_SH = SUM_W + $clog2(HISTORY_DEPTH);
   localparam int RCP_W   = SUM_W + 2;
   localparam int PROD_W  = SUM_W + RCP_W;
   localparam logic [RCP_W-1:0] MEAN_RCP =
      RCP_W'(((64'd1 << MEAN_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SUM       = 3'd1;
   localparam logic [2:0] ST_MEAN_GO   = 3'd2;
   localparam logic [2:0] ST_RATE_GO   = 3'd3;
   localparam logic [2:0] ST_RATE_WAIT = 3'd4;
   localparam logic [2:0] ST_RECORD    = 3'd5;
   localparam logic [2:0] ST_AVG_WAIT  = 3'd6;
   localparam logic [2:0] ST_EMIT      = 3'd7;

   logic [2:0]        state_ff, state_in;
   pbrd_pkg::job_type job_ff, job_in;
   logic [IB-1:0]     hist_ff [HISTORY_DEPTH];
   logic              hist_load, hist_seed;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [IB-1:0]     mean_ff, mean_in;
   logic [PROD_W-1:0] mean_prod;
   logic [RB-1:0]     rate_full_ff, rate_full_in;
   logic [7:0]        rate_ff, rate_in;
   logic [REC_W-1:0]  rsum_ff, rsum_in;
   logic [CNT_W-1:0]  rcnt_ff, rcnt_in;
   logic [7:0]        avg_ff, avg_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_load;
   logic              div_start, div_done;
   logic [DIV_W-1:0]  div_dividend, div_divisor, div_quotient;

   pbrd_divider #(.W(DIV_W)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign mean_prod = PROD_W'(acc_ff) * PROD_W'(MEAN_RCP);

   always_comb begin
      logic in_band;

      state_in     = state_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      mean_in      = mean_ff;
      rate_full_in = rate_full_ff;
      rate_in      = rate_ff;
      rsum_in      = rsum_ff;
      rcnt_in      = rcnt_ff;
      avg_in       = avg_ff;
      job_pop      = 1'b0;
      hist_load    = 1'b0;
      hist_seed    = 1'b0;
      out_load     = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      in_band      = (rate_full_ff >= {8'b0, record_low_bpm})
                     && (rate_full_ff <= {8'b0, record_high_bpm});

      unique case (state_ff)
         ST_IDLE: begin
            if (job_ready) begin
               job_pop = 1'b1;
               job_in  = job;
               if (job.compute) begin
                  hist_load = 1'b1;
                  hist_seed = job.seed;
                  idx_in    = '0;
                  acc_in    = '0;
                  state_in  = ST_SUM;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SUM: begin
            acc_in = acc_ff + SUM_W'(hist_ff[idx_ff]);
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(HISTORY_DEPTH - 1)) begin
               state_in = ST_MEAN_GO;
            end
         end
         ST_MEAN_GO: begin
            mean_in  = IB'(mean_prod >> MEAN_SH);
            state_in = ST_RATE_GO;
         end
         ST_RATE_GO: begin
            if (mean_ff == '0) begin
               rate_full_in = RB'(255);
               state_in     = ST_RECORD;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(pbrd_pkg::RATE_NUMERATOR);
               div_divisor  = DIV_W'(mean_ff);
               state_in     = ST_RATE_WAIT;
            end
         end
         ST_RATE_WAIT: begin
            if (div_done) begin
               rate_full_in = div_quotient[RB-1:0];
               state_in     = ST_RECORD;
            end
         end
         ST_RECORD: begin
            rate_in = (rate_full_ff > RB'(255)) ? 8'd255 : rate_full_ff[7:0];
            if (in_band && rcnt_ff < CNT_W'(MAX_RECORDS)) begin
               rsum_in      = rsum_ff + REC_W'(rate_full_ff[7:0]);
               rcnt_in      = rcnt_ff + 1'b1;
               div_start    = 1'b1;
               div_dividend = DIV_W'(rsum_in);
               div_divisor  = DIV_W'(rcnt_in);
               state_in     = ST_AVG_WAIT;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_AVG_WAIT: begin
            if (div_done) begin
               avg_in   = div_quotient[7:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_pop) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase

      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         rate_ff      <= '0;
         rsum_ff      <= '0;
         rcnt_ff      <= '0;
         avg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         rate_ff      <= rate_in;
         rsum_ff      <= rsum_in;
         rcnt_ff      <= rcnt_in;
         avg_ff       <= avg_in;
      end
      job_ff       <= job_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      mean_ff      <= mean_in;
      rate_full_ff <= rate_full_in;
      if (hist_load) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (hist_seed || i == HISTORY_DEPTH - 1) begin
               hist_ff[i] <= job.interval;
            end else begin
               hist_ff[i] <= hist_ff[i + 1];
            end
         end
      end
      if (out_load) begin
         rsp_beats_per_minute  <= rate_ff;
         rsp_new_rate          <= job_ff.compute;
         rsp_in_pulse          <= job_ff.pulse;
         rsp_current_threshold <= job_ff.threshold;
         rsp_beat_interval     <= job_ff.interval;
         rsp_recorded_count    <= rcnt_ff;
         rsp_recorded_average  <= avg_ff;
         rsp_average_in_band   <= (avg_ff >= record_low_bpm) && (avg_ff <= record_high_bpm);
      end
   end

   assign rsp_empty = !out_valid_ff;

endmodule

// File: hw/rtl/pulse_beat_rate_detector.sv
// Pulse sensor beat detector and heart rate estimator, top level.
//
// Samples enter on the req_ queue port: one sample is taken at an edge with
// req_push high and req_full low. Each sample yields exactly one result on the
// rsp_ queue port, shown while rsp_empty is low and taken with rsp_pop.
// The csr_ port writes the eight settings registers, one per edge with csr_we.
//
// The front end classifies a sample in the cycle it is taken and queues a job
// for the rate engine; it accepts a sample per cycle while the two-entry job
// queue has room, and sustained throughput is one sample per engine run.
// A sample without a new rate passes from the job queue through the engine's
// idle and emit states into the result register. A sample that yields a rate
// sums the interval history, forms the mean by reciprocal multiply, then runs
// one serial division for the rate (none when the mean is zero) and, when the
// rate is recorded, one more for the average (DIV_W = 16 at default settings).
// A stalled result port holds the result; the engine then waits and, once the
// queue fills, req_full rises. Synchronous reset empties both ports, returns
// the settings to their defaults and the detector to its unarmed state.
`timescale 1ns / 1ps
module pulse_beat_rate_detector #(
   parameter int HISTORY_DEPTH = pbrd_pkg::HISTORY_DEPTH_DEF,
   parameter int MAX_RECORDS   = pbrd_pkg::MAX_RECORDS_DEF,
   parameter int CNT_W         = $clog2(MAX_RECORDS + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [pbrd_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [7:0]                           rsp_beats_per_minute,
   output logic                                 rsp_new_rate,
   output logic                                 rsp_in_pulse,
   output logic [pbrd_pkg::SAMPLE_BITS-1:0]     rsp_current_threshold,
   output logic [pbrd_pkg::INTERVAL_BITS-1:0]   rsp_beat_interval,
   output logic [CNT_W-1:0]                     rsp_recorded_count,
   output logic [7:0]                           rsp_recorded_average,
   output logic                                 rsp_average_in_band,
   input  logic                                 csr_we,
   input  logic [pbrd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pbrd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   pbrd_pkg::cfg_type cfg_ff, cfg_in;
   pbrd_pkg::job_type front_job, queue_job;
   logic              accept, queue_empty, job_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pbrd_pkg::CSR_SAMPLE_PERIOD:  cfg_in.sample_period_ms  = csr_wdata[7:0];
            pbrd_pkg::CSR_INIT_THRESHOLD: cfg_in.initial_threshold = csr_wdata[9:0];
            pbrd_pkg::CSR_INIT_LEVEL:     cfg_in.initial_level     = csr_wdata[9:0];
            pbrd_pkg::CSR_TROUGH_HOLD:    cfg_in.trough_hold_ms    = csr_wdata;
            pbrd_pkg::CSR_REFRACTORY:     cfg_in.refractory_ms     = csr_wdata;
            pbrd_pkg::CSR_TIMEOUT:        cfg_in.timeout_ms        = csr_wdata;
            pbrd_pkg::CSR_RECORD_LOW:     cfg_in.record_low_bpm    = csr_wdata[7:0];
            pbrd_pkg::CSR_RECORD_HIGH:    cfg_in.record_high_bpm   = csr_wdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pbrd_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept = req_push && !req_full;

   pbrd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .sample (req_sample),
      .job    (front_job)
   );

   pbrd_queue #(.DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_job),
      .pop       (job_pop),
      .pop_data  (queue_job),
      .full      (req_full),
      .empty     (queue_empty)
   );

   pbrd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .MAX_RECORDS   (MAX_RECORDS),
      .CNT_W         (CNT_W)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .record_low_bpm        (cfg_ff.record_low_bpm),
      .record_high_bpm       (cfg_ff.record_high_bpm),
      .job_ready             (!queue_empty),
      .job                   (queue_job),
      .job_pop               (job_pop),
      .rsp_pop               (rsp_pop),
      .rsp_empty             (rsp_empty),
      .rsp_beats_per_minute  (rsp_beats_per_minute),
      .rsp_new_rate          (rsp_new_rate),
      .rsp_in_pulse          (rsp_in_pulse),
      .rsp_current_threshold (rsp_current_threshold),
      .rsp_beat_interval     (rsp_beat_interval),
      .rsp_recorded_count    (rsp_recorded_count),
      .rsp_recorded_average  (rsp_recorded_average),
      .rsp_average_in_band   (rsp_average_in_band)
   );

endmodule

// File: hw/rtl/pbrd_checker.sv
// Port-level checks of the detector, bound to the top level.
`timescale 1ns / 1ps
`include "pulse_beat_rate_detector_defines.svh"
module pbrd_checker #(
   parameter int MAX_RECORDS = pbrd_pkg::MAX_RECORDS_DEF,
   parameter int CNT_W       = $clog2(MAX_RECORDS + 1)
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_push,
   input logic                                 req_full,
   input logic [pbrd_pkg::SAMPLE_BITS-1:0]     req_sample,
   input logic                                 rsp_empty,
   input logic                                 rsp_pop,
   input logic [7:0]                           rsp_beats_per_minute,
   input logic                                 rsp_new_rate,
   input logic                                 rsp_in_pulse,
   input logic [pbrd_pkg::SAMPLE_BITS-1:0]     rsp_current_threshold,
   input logic [pbrd_pkg::INTERVAL_BITS-1:0]   rsp_beat_interval,
   input logic [CNT_W-1:0]                     rsp_recorded_count,
   input logic [7:0]                           rsp_recorded_average,
   input logic                                 rsp_average_in_band,
   input logic                                 csr_we,
   input logic [pbrd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input logic [pbrd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   `PBRD_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> rsp_empty, "result left after reset")

   `PBRD_ASSERT(a_count_bound, clock, reset,
      !rsp_empty |-> rsp_recorded_count <= CNT_W'(MAX_RECORDS), "record count above capacity")

   `PBRD_ASSERT(a_rate_in_pulse, clock, reset,
      (!rsp_empty && rsp_new_rate) |-> rsp_in_pulse, "new rate without an active pulse")

   `PBRD_ASSERT(a_no_records_no_avg, clock, reset,
      (!rsp_empty && rsp_recorded_count == '0) |-> rsp_recorded_average == 8'd0,
      "average reported with no records")

endmodule

bind pulse_beat_rate_detector pbrd_checker #(
   .MAX_RECORDS (MAX_RECORDS),
   .CNT_W       (CNT_W)
) u_pbrd_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the pulse beat rate detector.
`timescale 1ns / 1ps
module testbench;

   localparam int LIMIT      = 500000;
   localparam int HOLD_OFF   = 400;
   localparam int SETTLE     = 100;
   localparam int PHASE_ITEMS = 115;

   typedef struct packed {
      logic [7:0]  bpm;
      logic        fresh;
      logic        pulse;
      logic [9:0]  thr;
      logic [11:0] intv;
      logic [4:0]  cnt;
      logic [7:0]  avg;
      logic        band;
   } beat_result_type;

   typedef struct packed {
      logic [9:0]      sample;
      logic            typed;
      beat_result_type want;
   } sample_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [9:0]  req_sample = '0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [7:0]  rsp_beats_per_minute;
   logic        rsp_new_rate;
   logic        rsp_in_pulse;
   logic [9:0]  rsp_current_threshold;
   logic [11:0] rsp_beat_interval;
   logic [4:0]  rsp_recorded_count;
   logic [7:0]  rsp_recorded_average;
   logic        rsp_average_in_band;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [11:0] csr_wdata = '0;

   pulse_beat_rate_detector dut (.*);

   always #1 clock = ~clock;

   // detector state mirror
   pbrd_pkg::cfg_type cfg;
   logic [31:0]  clk_ms, beat_ms;
   logic [9:0]   peak, trough, thr;
   logic         pulse, armed1, armed2;
   int           hist [10];
   logic [7:0]   bpm;
   int           rec_sum, rec_cnt;

   beat_result_type pending_results[$];
   int errors = 0, cycles = 0, items_sent = 0, items_checked = 0, rates_seen = 0;
   bit steady = 0, hold_req = 0;

   function automatic beat_result_type detect_step(logic [9:0] s);
      logic [31:0]  n;
      logic [11:0]  intv;
      logic         fresh, armed_only;
      int           total, mean, rate, amp, t, avg;
      beat_result_type r;
      fresh = 0;
      armed_only = 0;
      clk_ms = clk_ms + cfg.sample_period_ms;
      n = clk_ms - beat_ms;
      intv = (n > 4095) ? 12'd4095 : n[11:0];
      if (s < thr && n > cfg.trough_hold_ms && s < trough) trough = s;
      if (s > thr && s > peak) peak = s;
      if (n > cfg.refractory_ms && n > cfg.trough_hold_ms && s > thr && !pulse) begin
         pulse = 1;
         beat_ms = clk_ms;
         if (armed2) begin
            armed2 = 0;
            for (int i = 0; i < 10; i++) hist[i] = intv;
         end
         if (armed1) begin
            armed1 = 0;
            armed2 = 1;
            armed_only = 1;
         end else begin
            total = 0;
            for (int i = 0; i < 9; i++) begin
               hist[i] = hist[i+1];
               total += hist[i];
            end
            hist[9] = intv;
            total += intv;
            mean = total / 10;
            rate = (mean == 0) ? 255 : 60000 / mean;
            bpm = (rate > 255) ? 8'd255 : rate[7:0];
            fresh = 1;
            if (rate >= int'(cfg.record_low_bpm) && rate <= int'(cfg.record_high_bpm)
                && rec_cnt < 20) begin
               rec_sum += rate;
               rec_cnt++;
            end
         end
      end
      if (!armed_only) begin
         // falling edge: recenter the threshold between trough and peak
         if (s < thr && pulse) begin
            amp = int'(peak) - int'(trough);
            t = int'(trough) + amp / 2;
            if (t < 0) t = 0;
            if (t > 1023) t = 1023;
            pulse = 0;
            thr = t[9:0];
            peak = thr;
            trough = thr;
         end
         if (n > cfg.timeout_ms) begin
            thr = cfg.initial_threshold;
            peak = cfg.initial_level;
            trough = cfg.initial_level;
            beat_ms = clk_ms;
            armed1 = 1;
            armed2 = 0;
         end
      end
      avg = (rec_cnt != 0) ? rec_sum / rec_cnt : 0;
      r.bpm = bpm;
      r.fresh = fresh;
      r.pulse = pulse;
      r.thr = thr;
      r.intv = intv;
      r.cnt = rec_cnt[4:0];
      r.avg = avg[7:0];
      r.band = (avg >= int'(cfg.record_low_bpm) && avg <= int'(cfg.record_high_bpm));
      return r;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // result side: random pops, one long hold-off on request
   initial begin : result_drain
      int stall_left;
      beat_result_type want;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               $error("result with no item outstanding");
               errors++;
            end else begin
               want = pending_results.pop_front();
               check_field("beats_per_minute", want.bpm, rsp_beats_per_minute);
               check_field("new_rate", want.fresh, rsp_new_rate);
               check_field("in_pulse", want.pulse, rsp_in_pulse);
               check_field("current_threshold", want.thr, rsp_current_threshold);
               check_field("beat_interval", want.intv, rsp_beat_interval);
               check_field("recorded_count", want.cnt, rsp_recorded_count);
               check_field("recorded_average", want.avg, rsp_recorded_average);
               check_field("average_in_band", want.band, rsp_average_in_band);
               items_checked++;
               if (rsp_new_rate) rates_seen++;
            end
         end
         if (hold_req) begin
            hold_req = 0;
            stall_left = HOLD_OFF;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 0;
         end else begin
            rsp_pop <= steady || ($urandom_range(99) >= 21);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // offer one sample; return after the edge that takes it
   task automatic push_sample(logic [9:0] s, bit typed, beat_result_type want);
      beat_result_type got;
      while (!steady && $urandom_range(99) < 21) begin
         req_push <= 0;
         @(posedge clock);
      end
      req_push <= 1;
      req_sample <= s;
      do @(posedge clock); while (req_full);
      got = detect_step(s);
      pending_results.push_back(typed ? want : got);
      items_sent++;
   endtask

   task automatic write_settings(pbrd_pkg::cfg_type c);
      logic [2:0]  idx [8];
      logic [11:0] val [8];
      idx = '{pbrd_pkg::CSR_SAMPLE_PERIOD, pbrd_pkg::CSR_INIT_THRESHOLD,
              pbrd_pkg::CSR_INIT_LEVEL, pbrd_pkg::CSR_TROUGH_HOLD,
              pbrd_pkg::CSR_REFRACTORY, pbrd_pkg::CSR_TIMEOUT,
              pbrd_pkg::CSR_RECORD_LOW, pbrd_pkg::CSR_RECORD_HIGH};
      val = '{12'(c.sample_period_ms), 12'(c.initial_threshold), 12'(c.initial_level),
              c.trough_hold_ms, c.refractory_ms, c.timeout_ms,
              12'(c.record_low_bpm), 12'(c.record_high_bpm)};
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 0;
      cfg = c;
   endtask

   task automatic drain_results();
      req_push <= 0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : stimulus
      sample_row_type    rows [16];
      beat_result_type   none;
      pbrd_pkg::cfg_type c;
      int                hi_len, lo_len, sent;
      logic [9:0]        hi_lvl;

      none = '0;
      rows[0] = '{10'd0,    1'b1, '{8'd0, 1'b0, 1'b0, 10'd530, 12'd2, 5'd0, 8'd0, 1'b0}};
      rows[1] = '{10'd1023, 1'b1, '{8'd0, 1'b0, 1'b0, 10'd530, 12'd4, 5'd0, 8'd0, 1'b0}};
      rows[2] = '{10'd1023, 1'b1, '{8'd0, 1'b0, 1'b0, 10'd530, 12'd6, 5'd0, 8'd0, 1'b0}};
      rows[3] = '{10'd530, 1'b0, none};
      rows[4] = '{10'd531, 1'b0, none};
      rows[5] = '{10'd529, 1'b0, none};
      rows[6] = '{10'd1, 1'b0, none};
      rows[7] = '{10'd512, 1'b0, none};
      rows[8] = '{10'd511, 1'b0, none};
      rows[9] = '{10'd0, 1'b0, none};
      rows[10] = '{10'h2aa, 1'b0, none};
      rows[11] = '{10'h155, 1'b0, none};
      rows[12] = '{10'd1022, 1'b0, none};
      rows[13] = '{10'd0, 1'b0, none};
      rows[14] = '{10'd1023, 1'b0, none};
      rows[15] = '{10'd0, 1'b0, none};

      cfg = pbrd_pkg::CFG_RESET;
      clk_ms = 0;
      beat_ms = 0;
      thr = cfg.initial_threshold;
      peak = cfg.initial_level;
      trough = cfg.initial_level;
      pulse = 0;
      armed1 = 1;
      armed2 = 0;
      for (int i = 0; i < 10; i++) hist[i] = 0;
      bpm = 0;
      rec_sum = 0;
      rec_cnt = 0;

      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i]) push_sample(rows[i].sample, rows[i].typed, rows[i].want);
      drain_results();

      for (int p = 0; p < 8; p++) begin
         c.sample_period_ms = $urandom_range(80, 20);
         c.initial_threshold = $urandom_range(700, 300);
         c.initial_level = $urandom_range(1023);
         c.trough_hold_ms = $urandom_range(150);
         c.refractory_ms = $urandom_range(300);
         c.timeout_ms = $urandom_range(4095, 600);
         c.record_low_bpm = $urandom_range(120);
         c.record_high_bpm = $urandom_range(255, 120);
         case (p)
            1: begin
               // minimum everywhere: every sample that does not arm a beat times out
               c = '0;
               c.sample_period_ms = 8'd1;
            end
            2: begin
               // maximum everywhere: no sample can clear the threshold
               c = '{8'd255, 10'd1023, 10'd1023, 12'd4095, 12'd4095, 12'd4095,
                     8'd255, 8'd255};
            end
            3: begin
               // zero hold-offs at 1 ms: rates saturate at the top
               c.sample_period_ms = 8'd1;
               c.trough_hold_ms = '0;
               c.refractory_ms = '0;
               c.record_low_bpm = '0;
               c.record_high_bpm = 8'd255;
            end
            4: c.timeout_ms = 12'd4095;
            5: begin
               c.record_low_bpm = '0;
               c.record_high_bpm = 8'd255;
            end
            default: ;
         endcase
         write_settings(c);
         steady = (p == 4);
         if (p == 5) hold_req = 1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(99) < 85) begin
               hi_len = $urandom_range(3, 1);
               lo_len = $urandom_range(8, 2);
               hi_lvl = $urandom_range(1023, 600);
               for (int k = 0; k < hi_len; k++) push_sample(hi_lvl - k, 0, none);
               for (int k = 0; k < lo_len; k++)
                  push_sample($urandom_range(400), 0, none);
               sent += hi_len + lo_len;
            end else begin
               push_sample($urandom_range(1023), 0, none);
               sent++;
            end
         end
         drain_results();
         steady = 0;
      end

      $display("Pushed %0d samples over nine register settings, checked %0d results,",
               items_sent, items_checked);
      $display("%0d of them carrying a new rate; %0d mismatches.", rates_seen, errors);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
